// ===== rtl/lrt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lrt_pkg: shared types and constants of the LRU recency tracker
// Sizes of the cell chain, the field widths, the operation and status
// codes, and the control bundle that the controller drives to every cell.
// ----------------------------------------------------------------------------
package lrt_pkg;

  // Number of cells in the chain and the width of a stored key.
  localparam int DEPTH     = 32;
  localparam int KEY_WIDTH = 32;

  // Derived widths.
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CAP_W = 5;
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  // Port field widths.
  localparam int KEY_PORT_W = 32;
  localparam int COUNT_W    = 6;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 2;

  // Register map.
  localparam logic [APB_ADDR_W-1:0] ADDR_CAPACITY = 2'd0;
  localparam logic [CAP_W-1:0]      CAPACITY_RESET = 5'd20;

  // Operation codes.
  localparam logic OP_USE  = 1'b0;
  localparam logic OP_PULL = 1'b1;

  // Status codes.
  localparam logic STAT_OK    = 1'b0;
  localparam logic STAT_EMPTY = 1'b1;

  // Control bundle broadcast to every cell.
  typedef struct packed {
    logic                 cmp_en;  // latch this cell's match flag
    logic                 upd_en;  // apply the shift of a use word
    logic [KEY_WIDTH-1:0] key;     // key of the word in flight
  } cell_ctrl_t;

endpackage : lrt_pkg
`default_nettype wire

// ===== rtl/lrt_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lrt_cell: one position of the recency chain
// Holds one key, compares it with the key in flight, and on a use takes
// the key of its left neighbor when the shift reaches it.
// ----------------------------------------------------------------------------
module lrt_cell (
  input  wire                                    clk_i,
  input  wire                                    rst_ni,
  input  lrt_pkg::cell_ctrl_t                    ctrl_i,
  input  wire                                    occ_i,
  input  wire                                    left_occ_i,
  input  wire  [lrt_pkg::KEY_WIDTH-1:0]          left_key_i,
  input  wire                                    seen_i,
  output logic [lrt_pkg::KEY_WIDTH-1:0]          key_o,
  output logic                                   seen_o
);
  import lrt_pkg::*;

  logic [KEY_WIDTH-1:0] key_q;
  logic                 match_q;
  logic                 match_d;
  logic                 shift;

  // Only a held entry may match; the stored key of a free cell is unknown.
  assign match_d = ctrl_i.cmp_en ? (occ_i && (key_q == ctrl_i.key)) : match_q;

  // A cell moves when its left neighbor holds an entry and no cell to its
  // left matched: everything up to and including the hit moves one place.
  assign shift = ctrl_i.upd_en && left_occ_i && !seen_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else begin
      match_q <= match_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift) begin
      key_q <= left_key_i;
    end
  end

  assign key_o  = key_q;
  assign seen_o = seen_i | match_q;

endmodule : lrt_cell
`default_nettype wire

// ===== rtl/lru_recency_tracker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lru_recency_tracker: LRU replacement list built as a chain of key cells
// Keeps keys ordered by recency in a row of cells, the most recent in
// cell 0, and answers use and pull words with one result word each.
// ----------------------------------------------------------------------------
// Each input word passes through a compare state and then an update
// state. In the compare state every cell compares its key with the word's
// key at once and latches a match flag. In the update state a use shifts
// every cell up to the hit (or up to the end of the held entries on a
// miss) one place back and writes the key into cell 0, while a pull reads
// the last held cell; the result word is loaded into the output register
// in that same cycle, and the next input word is accepted at the same
// edge, so a new word is taken only as the last one commits, after the
// compare and the shift of the chain. A result waiting in the output
// register holds the update cycle only when the previous result has not
// been taken yet. On a use miss with all cells held, the key in the last
// cell falls off the end and is returned with dropped set. The capacity
// register at byte address 0 only sets the full_res flag; it does not
// limit how many keys are held. There is no clearing pass after reset:
// free cells are never compared or read.
// ----------------------------------------------------------------------------
module lru_recency_tracker (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  // Input words.
  input  wire                                 in_valid_i,
  output logic                                in_stall_o,
  input  wire                                 operation_i,
  input  wire  [lrt_pkg::KEY_PORT_W-1:0]      key_i,
  // Result words.
  output logic                                out_valid_o,
  input  wire                                 out_stall_i,
  output logic                                status_o,
  output logic [lrt_pkg::KEY_PORT_W-1:0]      key_out_o,
  output logic                                was_hit_o,
  output logic                                dropped_o,
  output logic [lrt_pkg::COUNT_W-1:0]         count_o,
  output logic                                full_res_o,
  // Configuration port.
  input  wire                                 psel,
  input  wire                                 penable,
  input  wire                                 pwrite,
  input  wire  [lrt_pkg::APB_ADDR_W-1:0]      paddr,
  input  wire  [lrt_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [lrt_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                pready
);
  import lrt_pkg::*;

  // Sequencer states.
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CMP  = 2'd1;
  localparam logic [1:0] ST_UPD  = 2'd2;

  logic [1:0]           state_q, state_d;
  logic                 op_q;
  logic [KEY_WIDTH-1:0] key_q;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [CAP_W-1:0]     capacity_q;

  logic                 out_valid_q;
  logic                 status_q, status_d;
  logic [KEY_WIDTH-1:0] key_out_q, key_out_d;
  logic                 hit_q, hit_d;
  logic                 drop_q, drop_d;
  logic [CNT_W-1:0]     count_q;
  logic                 full_q, full_d;

  logic                 can_commit;
  logic                 commit;
  logic                 in_accept;
  cell_ctrl_t           cell_ctrl;

  logic [KEY_WIDTH-1:0] cell_key [DEPTH];
  logic [DEPTH-1:0]     occ_vec;
  logic [DEPTH:0]       seen;
  logic                 hit;
  logic [IDX_W-1:0]     last_idx;

  // --------------------------------------------------------------------------
  // Handshake. The update cycle may finish when the output register is free
  // or is being emptied at this edge; a new word enters at that same edge.
  // --------------------------------------------------------------------------
  assign can_commit = !out_valid_q || !out_stall_i;
  assign commit     = (state_q == ST_UPD) && can_commit;
  assign in_stall_o = !((state_q == ST_IDLE) || commit);
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_CMP;
        end
      end
      ST_CMP: begin
        state_d = ST_UPD;
      end
      ST_UPD: begin
        if (can_commit) begin
          state_d = in_valid_i ? ST_CMP : ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q  <= operation_i;
      key_q <= key_i[KEY_WIDTH-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Cell chain. Cell 0 is fed by the key in flight and always counts as
  // having a held neighbor, so it takes the key on every use.
  // --------------------------------------------------------------------------
  assign cell_ctrl.cmp_en = (state_q == ST_CMP);
  assign cell_ctrl.upd_en = commit && (op_q == OP_USE);
  assign cell_ctrl.key    = key_q;
  assign seen[0]          = 1'b0;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [KEY_WIDTH-1:0] left_key;
    logic                 left_occ;

    assign occ_vec[g] = (cnt_q > CNT_W'(g));

    if (g == 0) begin : g_head
      assign left_key = key_q;
      assign left_occ = 1'b1;
    end else begin : g_body
      assign left_key = cell_key[g-1];
      assign left_occ = occ_vec[g-1];
    end

    lrt_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (cell_ctrl),
      .occ_i      (occ_vec[g]),
      .left_occ_i (left_occ),
      .left_key_i (left_key),
      .seen_i     (seen[g]),
      .key_o      (cell_key[g]),
      .seen_o     (seen[g+1])
    );
  end

  // Keys are unique among held cells, so at most one match flag is set.
  assign hit      = seen[DEPTH];
  assign last_idx = IDX_W'(cnt_q - 1'b1);

  // --------------------------------------------------------------------------
  // Result of the word in the update cycle.
  // --------------------------------------------------------------------------
  always_comb begin
    status_d  = STAT_OK;
    key_out_d = '0;
    hit_d     = 1'b0;
    drop_d    = 1'b0;
    cnt_d     = cnt_q;
    if (op_q == OP_USE) begin
      if (hit) begin
        hit_d = 1'b1;
      end else if (cnt_q == CNT_W'(DEPTH)) begin
        drop_d    = 1'b1;
        key_out_d = cell_key[DEPTH-1];
      end else begin
        cnt_d = cnt_q + 1'b1;
      end
    end else begin
      if (cnt_q == '0) begin
        status_d = STAT_EMPTY;
      end else begin
        cnt_d     = cnt_q - 1'b1;
        key_out_d = cell_key[last_idx];
      end
    end
    full_d = (CMP_W'(cnt_d) > CMP_W'(capacity_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (commit) begin
        cnt_q       <= cnt_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      status_q  <= status_d;
      key_out_q <= key_out_d;
      hit_q     <= hit_d;
      drop_q    <= drop_d;
      count_q   <= cnt_d;
      full_q    <= full_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign key_out_o   = KEY_PORT_W'(key_out_q);
  assign was_hit_o   = hit_q;
  assign dropped_o   = drop_q;
  assign count_o     = COUNT_W'(count_q);
  assign full_res_o  = full_q;

  // --------------------------------------------------------------------------
  // Configuration port: the capacity register sits at byte address 0.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CAPACITY_RESET;
    end else if (psel && penable && pwrite && (paddr == ADDR_CAPACITY)) begin
      capacity_q <= pwdata[CAP_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr)
      ADDR_CAPACITY: prdata = APB_DATA_W'(capacity_q);
      default:       prdata = '0;
    endcase
  end

  assign pready = 1'b1;

endmodule : lru_recency_tracker
`default_nettype wire

// ===== dv/tb_lru_recency_tracker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lru_recency_tracker: self-checking bench for the LRU recency tracker
// Drives use and pull words through the input channel, predicts every result
// word from a local recency list, and compares each result word field by
// field. It covers several capacity settings and several idling patterns.
// ----------------------------------------------------------------------------
module tb_lru_recency_tracker;
  import lrt_pkg::*;

  // One expected result word, laid out like the output ports.
  typedef struct packed {
    logic                  status;
    logic [KEY_PORT_W-1:0] key_out;
    logic                  was_hit;
    logic                  dropped;
    logic [COUNT_W-1:0]    count;
    logic                  full_res;
  } lru_result_t;

  // Clock, reset and every input of the block start at known values.
  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  operation_i = OP_USE;
  logic [KEY_PORT_W-1:0] key_i       = '0;
  logic                  out_stall_i = 1'b0;
  logic                  psel        = 1'b0;
  logic                  penable     = 1'b0;
  logic                  pwrite      = 1'b0;
  logic [APB_ADDR_W-1:0] paddr       = '0;
  logic [APB_DATA_W-1:0] pwdata      = '0;

  logic                  in_stall_o;
  logic                  out_valid_o;
  logic                  status_o;
  logic [KEY_PORT_W-1:0] key_out_o;
  logic                  was_hit_o;
  logic                  dropped_o;
  logic [COUNT_W-1:0]    count_o;
  logic                  full_res_o;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  // Local copy of the tracker: the recency list (most recent at index 0),
  // the number of held keys, and the capacity register.
  logic [KEY_WIDTH-1:0]  lru_keys [DEPTH];
  int                    held_keys   = 0;
  logic [CAP_W-1:0]      capacity_q  = CAPACITY_RESET;

  // Result words still owed by the block, oldest first.
  lru_result_t           pending_results [$];
  lru_result_t           oldest_result;
  int                    mismatch_count = 0;

  // Idling controls, in percent of cycles. The sender idles before a word,
  // the receiver raises its stall on any cycle.
  int                    send_idle_pct  = 0;
  int                    recv_stall_pct = 0;

  lru_recency_tracker DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .key_i       (key_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .key_out_o   (key_out_o),
    .was_hit_o   (was_hit_o),
    .dropped_o   (dropped_o),
    .count_o     (count_o),
    .full_res_o  (full_res_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // 12 ns clock.
  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Move entries 0..upto-1 one place back and put the key at the front.
  function automatic void shift_in(int upto, logic [KEY_WIDTH-1:0] key_val);
    for (int j = upto; j > 0; j--) begin
      if (j < DEPTH) lru_keys[j] = lru_keys[j - 1];
    end
    lru_keys[0] = key_val;
  endfunction

  // Apply one input word to the local list and return the result word that
  // the block has to produce for it.
  function automatic lru_result_t lru_step(logic op, logic [KEY_PORT_W-1:0] key_word);
    lru_result_t          res;
    int                   pos;
    logic [KEY_WIDTH-1:0] key_val;
    res     = '0;
    key_val = key_word[KEY_WIDTH-1:0];
    if (op == OP_USE) begin
      pos = held_keys;
      for (int j = 0; j < held_keys; j++) begin
        if (lru_keys[j] == key_val) begin
          pos = j;
          break;
        end
      end
      if (pos < held_keys) begin
        // A hit pulls the entry forward; nothing leaves the list.
        res.was_hit = 1'b1;
        shift_in(pos, key_val);
      end else if (held_keys >= DEPTH) begin
        // A miss with every cell held pushes the oldest key off the end.
        res.dropped = 1'b1;
        res.key_out = KEY_PORT_W'(lru_keys[DEPTH - 1]);
        shift_in(DEPTH - 1, key_val);
      end else begin
        shift_in(held_keys, key_val);
        held_keys++;
      end
    end else if (held_keys == 0) begin
      // A pull on an empty list changes nothing and reports it.
      res.status = STAT_EMPTY;
    end else begin
      held_keys--;
      res.key_out = KEY_PORT_W'(lru_keys[held_keys]);
    end
    res.count    = COUNT_W'(held_keys);
    res.full_res = (held_keys > int'(capacity_q));
    return res;
  endfunction

  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  // Send one word. The sender may idle at random first; valid then
  // stays high until the word is taken, and it is left high afterwards so
  // that a following word can go out with no bubble.
  task automatic send_word(input logic op, input logic [KEY_PORT_W-1:0] key_word);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    key_i       <= key_word;
    do @(posedge clk_i); while (in_stall_o);
    pending_results.push_back(lru_step(op, key_word));
  endtask

  // Lower valid and wait until every owed result word has come back, then
  // let the block settle.
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Write the capacity register through the configuration port while idle.
  task automatic write_capacity(input logic [CAP_W-1:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_CAPACITY;
    pwdata  <= APB_DATA_W'(value);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    capacity_q = value;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Receiver stall, redrawn on every falling edge.
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // Every result word taken is checked against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("result word with no expected result waiting");
        mismatch_count++;
      end else begin
        oldest_result = pending_results.pop_front();
        compare_field("status", 32'(oldest_result.status), 32'(status_o));
        compare_field("key_out", 32'(oldest_result.key_out), 32'(key_out_o));
        compare_field("was_hit", 32'(oldest_result.was_hit), 32'(was_hit_o));
        compare_field("dropped", 32'(oldest_result.dropped), 32'(dropped_o));
        compare_field("count", 32'(oldest_result.count), 32'(count_o));
        compare_field("full_res", 32'(oldest_result.full_res), 32'(full_res_o));
      end
    end
  end

  // Short directed run with the capacity still at its reset value: pull on an
  // empty list, keys at both extremes, hits at the front and deeper, and
  // pulls that walk the list back to empty.
  task automatic test_directed();
    send_word(OP_PULL, 32'h0000_0000);
    send_word(OP_USE,  32'h0000_0000);
    send_word(OP_USE,  32'hFFFF_FFFF);
    send_word(OP_USE,  32'h0000_0000);
    send_word(OP_USE,  32'h1234_5678);
    send_word(OP_USE,  32'h1234_5678);
    send_word(OP_PULL, 32'hFFFF_FFFF);
    send_word(OP_PULL, 32'h0000_0000);
    send_word(OP_PULL, 32'h1234_5678);
    send_word(OP_PULL, 32'hA5A5_A5A5);
    send_word(OP_USE,  32'hA5A5_A5A5);
    send_word(OP_USE,  32'h5A5A_5A5A);
    send_word(OP_USE,  32'h8000_0001);
    send_word(OP_USE,  32'hA5A5_A5A5);
    send_word(OP_PULL, 32'h0000_0000);
    send_word(OP_PULL, 32'h0000_0000);
    send_word(OP_PULL, 32'h0000_0000);
    send_word(OP_PULL, 32'h0000_0000);
    wait_idle();
  endtask

  // Fill the list past the capacity and past the last cell with distinct
  // random keys, so that full_res rises and the oldest keys fall off the end.
  // Then hit the oldest held key and pull everything out again.
  task automatic test_overflow();
    logic [KEY_PORT_W-1:0] key_word;
    for (int n = 0; n < DEPTH + 4; n++) begin
      key_word = {8'(n), 24'($urandom())};
      send_word(OP_USE, key_word);
    end
    send_word(OP_USE, 32'(lru_keys[held_keys - 1]));
    for (int n = 0; n <= DEPTH; n++) begin
      send_word(OP_PULL, 32'($urandom()));
    end
    wait_idle();
  endtask

  // Random traffic under one capacity setting and one idling pattern. The
  // mix switches at random between filling and draining stretches, and keys come
  // mostly from a small pool so that hits, misses and drops all happen.
  task automatic test_random_traffic(input logic [CAP_W-1:0] cap, input int items,
                                     input int idle_pct, input int stall_pct);
    logic                  op;
    logic [KEY_PORT_W-1:0] key_word;
    logic [KEY_PORT_W-1:0] pool_base;
    int                    sel;
    bit                    filling;
    write_capacity(cap);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    pool_base      = $urandom();
    filling        = 1'b1;
    for (int n = 0; n < items; n++) begin
      if (n % 40 == 0) filling = $urandom_range(1);
      op  = ($urandom_range(99) < (filling ? 20 : 60)) ? OP_PULL : OP_USE;
      sel = $urandom_range(99);
      if (sel < 55) begin
        key_word = pool_base + $urandom_range(47);
      end else if (sel < 75 && held_keys > 0) begin
        key_word = 32'(lru_keys[$urandom_range(held_keys - 1)]);
      end else if (sel < 93) begin
        key_word = $urandom();
      end else begin
        key_word = sel[0] ? '1 : '0;
      end
      send_word(op, key_word);
    end
    wait_idle();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_overflow();
    test_random_traffic(5'd0,  130, 0,  0);
    test_random_traffic(5'd31, 130, 73, 0);
    test_random_traffic(5'($urandom_range(31)), 130, 0,  73);
    test_random_traffic(5'($urandom_range(31)), 130, 16, 16);

    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #4_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
